FILE: hw/rtl/mrg_pkg.sv
// Package for the motor reversal guard: mode encoding, constants and result type.
// Used by mrg_step and motor_reversal_guard_fsm_unit; depends on nothing.
package mrg_pkg;

   localparam int DRIVE_W = 17;
   localparam int DUTY_W  = 16;
   localparam int COUNT_W = 8;

   localparam logic [COUNT_W-1:0] STOP_TICKS_RESET = 8'd30;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_CW   = 2'd1,
      MODE_ACW  = 2'd2,
      MODE_STOP = 2'd3
   } mode_type;

   typedef struct packed {
      logic              clockwise;
      logic [DUTY_W-1:0] duty;
      mode_type          mode_after;
   } result_type;

endpackage

FILE: hw/rtl/mrg_step.sv
// Next-mode, stop counter and result logic for one enabled or disabled tick.
// Depends on mrg_pkg.
module mrg_step (
   input  logic                        enable,
   input  logic signed [mrg_pkg::DRIVE_W-1:0] drive_request,
   input  mrg_pkg::mode_type           mode,
   input  logic [mrg_pkg::COUNT_W-1:0] stop_count,
   input  logic [mrg_pkg::COUNT_W-1:0] stop_ticks,
   output mrg_pkg::mode_type           mode_next,
   output logic [mrg_pkg::COUNT_W-1:0] stop_count_next,
   output mrg_pkg::result_type         result
);

   logic                        neg;
   logic                        req_cw;
   logic [mrg_pkg::DRIVE_W-1:0] mag;
   logic [mrg_pkg::DRIVE_W-1:0] duty_full;
   logic [mrg_pkg::COUNT_W-1:0] count_inc;
   logic                        stop_done;
   logic                        reversal;

   assign neg       = drive_request[mrg_pkg::DRIVE_W-1];
   assign req_cw    = ~neg;
   assign mag       = neg ? (~drive_request + 1'b1) : drive_request;
   assign count_inc = stop_count + 1'b1;
   assign stop_done = (count_inc >= stop_ticks);
   assign reversal  = ((mode == mrg_pkg::MODE_CW) && !req_cw) ||
                      ((mode == mrg_pkg::MODE_ACW) && req_cw);

   always_comb begin
      mode_next       = mode;
      stop_count_next = stop_count;
      if (!enable) begin
         mode_next       = mrg_pkg::MODE_IDLE;
         stop_count_next = '0;
      end else begin
         unique case (mode)
            mrg_pkg::MODE_IDLE: begin
               mode_next = req_cw ? mrg_pkg::MODE_CW : mrg_pkg::MODE_ACW;
            end
            mrg_pkg::MODE_CW, mrg_pkg::MODE_ACW: begin
               if (reversal) begin
                  mode_next = mrg_pkg::MODE_STOP;
               end
            end
            mrg_pkg::MODE_STOP: begin
               if (stop_done) begin
                  mode_next       = mrg_pkg::MODE_IDLE;
                  stop_count_next = '0;
               end else begin
                  stop_count_next = count_inc;
               end
            end
            default: begin
               mode_next = mrg_pkg::MODE_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      result.clockwise = req_cw;
      duty_full        = mag;
      unique case (mode)
         mrg_pkg::MODE_CW, mrg_pkg::MODE_ACW: begin
            if (reversal) begin
               result.clockwise = (mode == mrg_pkg::MODE_CW);
               duty_full        = mag >> 1;
            end
         end
         mrg_pkg::MODE_STOP: begin
            result.clockwise = 1'b1;
            duty_full        = '0;
         end
         default: begin
            result.clockwise = req_cw;
         end
      endcase
      result.duty       = duty_full[mrg_pkg::DRIVE_W-1] ? '1
                                                        : duty_full[mrg_pkg::DUTY_W-1:0];
      result.mode_after = mode_next;
   end

endmodule

FILE: hw/rtl/motor_reversal_guard_fsm_unit.sv
// Top level of the motor reversal guard: input register, mode state and result register.
// Depends on mrg_pkg and mrg_step.
// Each control tick is held in the input register, and the result of an enabled tick
// is then held in the result register. A new tick is taken every cycle while the
// result side keeps up. A disabled tick only resets the mode and the stop counter and
// gives no result; stop_ticks resets to 30.
module motor_reversal_guard_fsm_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_enable,
   input  logic signed [mrg_pkg::DRIVE_W-1:0]  req_drive_request,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_clockwise,
   output logic [mrg_pkg::DUTY_W-1:0]          rsp_duty,
   output logic [1:0]                          rsp_mode_after,
   input  logic                                csr_write_enable,
   input  logic [mrg_pkg::COUNT_W-1:0]         csr_write_data
);

   logic                               s1_valid_ff, s1_valid_in;
   logic                               s1_enable_ff;
   logic signed [mrg_pkg::DRIVE_W-1:0] s1_drive_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   mrg_pkg::result_type                rsp_data_ff;
   mrg_pkg::mode_type                  mode_ff, mode_in;
   logic [mrg_pkg::COUNT_W-1:0]        stop_count_ff, stop_count_in;
   logic [mrg_pkg::COUNT_W-1:0]        stop_ticks_ff;
   mrg_pkg::result_type                step_result;
   logic                               out_free;
   logic                               advance;
   logic                               req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && (!s1_enable_ff || out_free);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   mrg_step u_step (
      .enable          (s1_enable_ff),
      .drive_request   (s1_drive_ff),
      .mode            (mode_ff),
      .stop_count      (stop_count_ff),
      .stop_ticks      (stop_ticks_ff),
      .mode_next       (mode_in),
      .stop_count_next (stop_count_in),
      .result          (step_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && s1_enable_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= mrg_pkg::MODE_IDLE;
         stop_count_ff <= '0;
         stop_ticks_ff <= mrg_pkg::STOP_TICKS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff       <= mode_in;
            stop_count_ff <= stop_count_in;
         end
         if (csr_write_enable) begin
            stop_ticks_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_enable_ff <= req_enable;
         s1_drive_ff  <= req_drive_request;
      end
      if (advance && s1_enable_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clockwise  = rsp_data_ff.clockwise;
   assign rsp_duty       = rsp_data_ff.duty;
   assign rsp_mode_after = rsp_data_ff.mode_after;

   a_count_only_in_stop: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != mrg_pkg::MODE_STOP) |-> (stop_count_ff == '0))
      else $error("stop counter nonzero outside stop mode");

   a_enabled_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_enable_ff) |=> rsp_valid_ff)
      else $error("enabled tick did not load a result");

   a_idle_left_on_enabled_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_enable_ff && (mode_ff == mrg_pkg::MODE_IDLE))
      |=> (mode_ff != mrg_pkg::MODE_IDLE))
      else $error("enabled tick in idle did not latch a direction");

   a_disabled_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_enable_ff)
      |=> ((mode_ff == mrg_pkg::MODE_IDLE) && (stop_count_ff == '0)))
      else $error("disabled tick did not return to idle");

endmodule
